@@ rtl/core/acs_pkg.sv @@
// Package for the accumulator CPU step block: constants, decode and ALU functions,
// controller states and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package acs_pkg;

    localparam int MEM_AW    = 16;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_EXEC  = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    localparam logic [7:0] OP_NOP    = 8'h18;
    localparam logic [7:0] OP_HALT   = 8'h19;
    localparam logic [7:0] MATH_BIT  = 8'h80;
    localparam logic [7:0] MEM_MASK  = 8'hf0;
    localparam logic [7:0] BR_MASK   = 8'hf8;
    localparam logic [7:0] BR_CODE   = 8'h10;

    // Operand locations of math instructions.
    localparam logic [1:0] OPD_MAR_MEM = 2'd0;
    localparam logic [1:0] OPD_ACC     = 2'd1;
    localparam logic [1:0] OPD_IMM     = 2'd2;
    localparam logic [1:0] OPD_ABS     = 2'd3;

    // Addressing methods of loads and stores.
    localparam logic [1:0] MTD_ABS  = 2'd0;
    localparam logic [1:0] MTD_IMM  = 2'd1;
    localparam logic [1:0] MTD_MAR  = 2'd2;
    localparam logic [1:0] MTD_NONE = 2'd3;

    localparam logic [2:0] ALU_AND = 3'd0;
    localparam logic [2:0] ALU_OR  = 3'd1;
    localparam logic [2:0] ALU_XOR = 3'd2;
    localparam logic [2:0] ALU_ADD = 3'd3;
    localparam logic [2:0] ALU_SUB = 3'd4;
    localparam logic [2:0] ALU_INC = 3'd5;
    localparam logic [2:0] ALU_DEC = 3'd6;
    localparam logic [2:0] ALU_NOT = 3'd7;

    localparam logic [2:0] BR_ALWAYS = 3'd0;
    localparam logic [2:0] BR_EQ     = 3'd1;
    localparam logic [2:0] BR_NE     = 3'd2;
    localparam logic [2:0] BR_LT     = 3'd3;
    localparam logic [2:0] BR_LE     = 3'd4;
    localparam logic [2:0] BR_GT     = 3'd5;
    localparam logic [2:0] BR_GE     = 3'd6;
    localparam logic [2:0] BR_NEVER  = 3'd7;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WR, S_RD, S_RDW,
        S_F0, S_F1, S_F2, S_F3,
        S_RS, S_RSW, S_RDST, S_RDSTW, S_WD,
        S_MA0, S_MA1, S_MA2, S_ST0, S_ST1,
        S_CMT, S_HREAD, S_HWAIT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        A_PC, A_PC1, A_PC2, A_SRC, A_DST, A_EA, A_EA1, A_LOAD, A_CLR
    } t_asel;

    typedef enum logic [2:0] {
        W_ZERO, W_LOAD, W_ALU, W_ACC, W_MARH, W_MARL
    } t_wsel;

    typedef struct packed {
        t_asel asel;
        logic  we;
        t_wsel wsel;
        logic  cap_in;
        logic  cap_ir;
        logic  cap_b1;
        logic  cap_b2;
        logic  cap_s;
        logic  cap_d;
        logic  cap_lo;
        logic  cap_rd;
        logic  cap_halt;
        logic  commit;
        logic  out_load;
        logic  clr_inc;
    } t_cmd;

    typedef struct packed {
        logic [7:0] ir;
        logic       clr_last;
    } t_stat;

    function automatic logic is_math(input logic [7:0] ir);
        return (ir & MATH_BIT) == MATH_BIT;
    endfunction

    function automatic logic is_mem(input logic [7:0] ir);
        return (ir & MEM_MASK) == 8'h00;
    endfunction

    function automatic logic is_branch(input logic [7:0] ir);
        return (ir & BR_MASK) == BR_CODE;
    endfunction

    function automatic logic is_illegal(input logic [7:0] ir);
        return !(ir == OP_NOP || is_math(ir) || is_mem(ir) || is_branch(ir));
    endfunction

    function automatic logic [15:0] inst_len(input logic [7:0] ir);
        logic [15:0] len;
        len = 16'd1;
        if (is_math(ir)) begin
            if (ir[1:0] == OPD_ABS) begin
                len = len + 16'd2;
            end else if (ir[1:0] == OPD_IMM) begin
                len = len + ((ir[3:2] == OPD_IMM) ? 16'd2 : 16'd1);
            end
            if (ir[3:2] == OPD_ABS) begin
                len = len + 16'd2;
            end
        end else if (is_mem(ir)) begin
            if (ir[1:0] == MTD_ABS) begin
                len = 16'd3;
            end else if (ir[1:0] == MTD_IMM) begin
                len = ir[2] ? 16'd3 : 16'd2;
            end
        end else if (is_branch(ir)) begin
            len = 16'd3;
        end
        return len;
    endfunction

    function automatic logic [15:0] alu(input logic [2:0] fn, input logic [15:0] d,
                                        input logic [15:0] s);
        logic [15:0] r;
        unique case (fn)
            ALU_AND: r = d & s;
            ALU_OR:  r = d | s;
            ALU_XOR: r = d ^ s;
            ALU_ADD: r = d + s;
            ALU_SUB: r = d - s;
            ALU_INC: r = d + 16'd1;
            ALU_DEC: r = d - 16'd1;
            ALU_NOT: r = ~s;
            default: r = ~s;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/acs_in_if.sv @@
// Input channel of the accumulator CPU step block: valid/ready plus the request payload.
// Depends on nothing.
`default_nettype none

interface acs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] load_address;
    logic [7:0]  load_data;

    modport source (output valid, output func, output load_address, output load_data,
                    input ready);
    modport sink   (input valid, input func, input load_address, input load_data,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/acs_out_if.sv @@
// Output channel of the accumulator CPU step block: valid/ready plus the machine state.
// Depends on nothing.
`default_nettype none

interface acs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pc_value;
    logic [7:0]  acc_value;
    logic [15:0] mar_value;
    logic        halted;
    logic [7:0]  opcode_done;
    logic        illegal_op;
    logic [7:0]  read_data;

    modport source (output valid, output pc_value, output acc_value, output mar_value,
                    output halted, output opcode_done, output illegal_op,
                    output read_data, input ready);
    modport sink   (input valid, input pc_value, input acc_value, input mar_value,
                    input halted, input opcode_done, input illegal_op,
                    input read_data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/acs_ctrl.sv @@
// Sequencer of the accumulator CPU step block: one memory access per state.
// Depends on acs_pkg.
`default_nettype none

module acs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_func,
    output logic               o_in_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    input  wire acs_pkg::t_stat i_stat,
    output acs_pkg::t_cmd      o_cmd
);
    import acs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic [7:0] ir;

    assign ir          = i_stat.ir;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.asel  = A_PC;
        o_cmd.wsel  = W_ZERO;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.asel    = A_CLR;
                o_cmd.we      = 1'b1;
                o_cmd.clr_inc = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.cap_in = i_in_valid;
                if (i_in_valid) begin
                    priority case (i_func)
                        FN_WRITE: n_state = S_WR;
                        FN_EXEC:  n_state = S_F0;
                        FN_READ:  n_state = S_RD;
                        default:  n_state = S_HREAD;
                    endcase
                end
            end
            S_WR: begin
                o_cmd.asel = A_LOAD;
                o_cmd.we   = 1'b1;
                o_cmd.wsel = W_LOAD;
                n_state    = S_HREAD;
            end
            S_RD: begin
                o_cmd.asel = A_LOAD;
                n_state    = S_RDW;
            end
            S_RDW: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_HREAD;
            end
            S_F0: begin
                o_cmd.asel = A_PC;
                n_state    = S_F1;
            end
            S_F1: begin
                o_cmd.asel   = A_PC1;
                o_cmd.cap_ir = 1'b1;
                n_state      = S_F2;
            end
            S_F2: begin
                o_cmd.asel   = A_PC2;
                o_cmd.cap_b1 = 1'b1;
                n_state      = S_F3;
            end
            S_F3: begin
                o_cmd.cap_b2 = 1'b1;
                if (ir == OP_HALT) begin
                    n_state = S_HREAD;
                end else if (is_math(ir)) begin
                    if (ir[1:0] == OPD_MAR_MEM || ir[1:0] == OPD_ABS) begin
                        n_state = S_RS;
                    end else if (ir[3:2] == OPD_MAR_MEM || ir[3:2] == OPD_ABS) begin
                        n_state = S_RDST;
                    end else begin
                        n_state = S_CMT;
                    end
                end else if (is_mem(ir) && ir[1:0] != MTD_NONE && ir[1:0] != MTD_IMM) begin
                    n_state = ir[3] ? S_MA0 : S_ST0;
                end else begin
                    n_state = S_CMT;
                end
            end
            S_RS: begin
                o_cmd.asel = A_SRC;
                n_state    = S_RSW;
            end
            S_RSW: begin
                o_cmd.cap_s = 1'b1;
                if (ir[3:2] == OPD_MAR_MEM || ir[3:2] == OPD_ABS) begin
                    n_state = S_RDST;
                end else begin
                    n_state = S_CMT;
                end
            end
            S_RDST: begin
                o_cmd.asel = A_DST;
                n_state    = S_RDSTW;
            end
            S_RDSTW: begin
                o_cmd.cap_d = 1'b1;
                n_state     = S_WD;
            end
            S_WD: begin
                o_cmd.asel   = A_DST;
                o_cmd.we     = 1'b1;
                o_cmd.wsel   = W_ALU;
                o_cmd.commit = 1'b1;
                n_state      = S_HREAD;
            end
            S_MA0: begin
                o_cmd.asel = A_EA;
                n_state    = S_MA1;
            end
            S_MA1: begin
                o_cmd.asel  = A_EA1;
                o_cmd.cap_d = 1'b1;
                n_state     = S_MA2;
            end
            S_MA2: begin
                o_cmd.cap_lo = 1'b1;
                n_state      = S_CMT;
            end
            S_ST0: begin
                o_cmd.asel = A_EA;
                o_cmd.we   = 1'b1;
                o_cmd.wsel = ir[2] ? W_MARH : W_ACC;
                n_state    = ir[2] ? S_ST1 : S_CMT;
            end
            S_ST1: begin
                o_cmd.asel = A_EA1;
                o_cmd.we   = 1'b1;
                o_cmd.wsel = W_MARL;
                n_state    = S_CMT;
            end
            S_CMT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_HREAD;
            end
            S_HREAD: begin
                o_cmd.asel = A_PC;
                n_state    = S_HWAIT;
            end
            S_HWAIT: begin
                o_cmd.cap_halt = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // The result register is free once the previous transaction has gone.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/acs_dp.sv @@
// Datapath of the accumulator CPU step block: main memory, PC, ACC, MAR, operand
// registers, ALU and the result register. Depends on acs_pkg.
`default_nettype none

module acs_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire acs_pkg::t_cmd i_cmd,
    output acs_pkg::t_stat     o_stat,
    input  wire logic [15:0]   i_load_address,
    input  wire logic [7:0]    i_load_data,
    output logic [15:0]        o_pc_value,
    output logic [7:0]         o_acc_value,
    output logic [15:0]        o_mar_value,
    output logic               o_halted,
    output logic [7:0]         o_opcode_done,
    output logic               o_illegal_op,
    output logic [7:0]         o_read_data
);
    import acs_pkg::*;

    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_q;
    logic [MEM_AW-1:0] r_clr;
    logic [15:0]       r_pc, r_mar, r_laddr;
    logic [7:0]        r_acc, r_ldata, r_ir, r_b1, r_b2, r_s, r_d, r_lo, r_rd;
    logic [7:0]        r_done;
    logic              r_ill, r_halt;

    logic [15:0] abs_a, ea, addr, sval, dval, res, n_pc;
    logic [7:0]  wdata;
    logic        take;

    assign abs_a = {r_b1, r_b2};
    assign ea    = (r_ir[1:0] == MTD_ABS) ? abs_a : r_mar;

    assign o_stat.ir       = r_ir;
    assign o_stat.clr_last = &r_clr;

    always_comb begin
        unique case (i_cmd.asel)
            A_PC:    addr = r_pc;
            A_PC1:   addr = r_pc + 16'd1;
            A_PC2:   addr = r_pc + 16'd2;
            A_SRC:   addr = (r_ir[1:0] == OPD_MAR_MEM) ? r_mar : abs_a;
            A_DST:   addr = (r_ir[3:2] == OPD_MAR_MEM) ? r_mar : abs_a;
            A_EA:    addr = ea;
            A_EA1:   addr = ea + 16'd1;
            A_LOAD:  addr = r_laddr;
            A_CLR:   addr = 16'(r_clr);
            default: addr = r_pc;
        endcase
    end

    // Math operands; INC and DEC ignore the source and NOT ignores the destination.
    always_comb begin
        unique case (r_ir[1:0])
            OPD_MAR_MEM: sval = {8'd0, r_s};
            OPD_ACC:     sval = {8'd0, r_acc};
            OPD_IMM:     sval = (r_ir[3:2] == OPD_IMM) ? abs_a : {8'd0, r_b1};
            OPD_ABS:     sval = {8'd0, r_s};
            default:     sval = {8'd0, r_s};
        endcase
        unique case (r_ir[3:2])
            OPD_ACC: dval = {8'd0, r_acc};
            OPD_IMM: dval = r_mar;
            default: dval = {8'd0, r_d};
        endcase
        res = alu(r_ir[6:4], dval, sval);
    end

    always_comb begin
        unique case (i_cmd.wsel)
            W_ZERO:  wdata = 8'd0;
            W_LOAD:  wdata = r_ldata;
            W_ALU:   wdata = res[7:0];
            W_ACC:   wdata = r_acc;
            W_MARH:  wdata = r_mar[15:8];
            W_MARL:  wdata = r_mar[7:0];
            default: wdata = 8'd0;
        endcase
    end

    // Branch conditions read ACC as a signed byte.
    always_comb begin
        unique case (r_ir[2:0])
            BR_ALWAYS: take = 1'b1;
            BR_EQ:     take = (r_acc == 8'd0);
            BR_NE:     take = (r_acc != 8'd0);
            BR_LT:     take = r_acc[7];
            BR_LE:     take = r_acc[7] || (r_acc == 8'd0);
            BR_GT:     take = !r_acc[7] && (r_acc != 8'd0);
            BR_GE:     take = !r_acc[7];
            BR_NEVER:  take = 1'b0;
            default:   take = 1'b0;
        endcase
        n_pc = (is_branch(r_ir) && take) ? abs_a : r_pc + inst_len(r_ir);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[addr[MEM_AW-1:0]] <= wdata;
        end
        r_q <= r_mem[addr[MEM_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_pc  <= 16'd0;
            r_acc <= 8'd0;
            r_mar <= 16'd0;
        end else begin
            if (i_cmd.clr_inc) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.commit) begin
                r_pc <= n_pc;
                if (is_math(r_ir)) begin
                    if (r_ir[3:2] == OPD_ACC) begin
                        r_acc <= res[7:0];
                    end else if (r_ir[3:2] == OPD_IMM) begin
                        r_mar <= res;
                    end
                end else if (is_mem(r_ir) && r_ir[3] && r_ir[1:0] != MTD_NONE) begin
                    if (r_ir[2]) begin
                        r_mar <= (r_ir[1:0] == MTD_IMM) ? abs_a : {r_d, r_lo};
                    end else begin
                        r_acc <= (r_ir[1:0] == MTD_IMM) ? r_b1 : r_d;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_laddr <= i_load_address;
            r_ldata <= i_load_data;
            r_done  <= 8'd0;
            r_ill   <= 1'b0;
            r_rd    <= 8'd0;
        end
        if (i_cmd.commit) begin
            r_done <= r_ir;
            r_ill  <= is_illegal(r_ir);
        end
        if (i_cmd.cap_ir)   r_ir   <= r_q;
        if (i_cmd.cap_b1)   r_b1   <= r_q;
        if (i_cmd.cap_b2)   r_b2   <= r_q;
        if (i_cmd.cap_s)    r_s    <= r_q;
        if (i_cmd.cap_d)    r_d    <= r_q;
        if (i_cmd.cap_lo)   r_lo   <= r_q;
        if (i_cmd.cap_rd)   r_rd   <= r_q;
        if (i_cmd.cap_halt) r_halt <= (r_q == OP_HALT);
        if (i_cmd.out_load) begin
            o_pc_value    <= r_pc;
            o_acc_value   <= r_acc;
            o_mar_value   <= r_mar;
            o_halted      <= r_halt;
            o_opcode_done <= r_done;
            o_illegal_op  <= r_ill;
            o_read_data   <= r_rd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/accumulator_cpu_step.sv @@
// Top level of the accumulator CPU step block: an 8-bit accumulator machine with
// byte memory. Depends on acs_pkg, acs_in_if, acs_out_if, acs_ctrl and acs_dp.
//
// Usage: each input transaction on i_in either writes a memory byte (func 0),
// executes the instruction at PC (func 1) or reads a memory byte (func 2); func 3
// changes nothing. Every input transaction gives exactly one output transaction on
// o_out that reports PC, ACC, MAR, the halt flag, the executed opcode, the illegal
// flag and the byte read.
// Sequence: all work goes through the single memory port, one access per cycle. A
// write passes a write state, a read its read and capture states; an instruction
// fetches its opcode and two following bytes, then reads memory operands and writes
// back, loads or stores, and commits. Each transaction ends with a read of the byte
// at PC for the halt flag; the next is accepted in the cycle after the result is loaded.
// Reset: PC, ACC and MAR clear, then the controller sweeps all 65536 memory bytes
// to zero, one per cycle, and accepts nothing during the sweep.
// Stall: a finished result waits in the output register; the block accepts and
// works on the next transaction meanwhile and holds it only at the result load.
`default_nettype none

module accumulator_cpu_step (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    acs_in_if.sink    i_in,
    acs_out_if.source o_out
);
    import acs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    acs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_func      (i_in.func),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    acs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_load_address (i_in.load_address),
        .i_load_data    (i_in.load_data),
        .o_pc_value     (o_out.pc_value),
        .o_acc_value    (o_out.acc_value),
        .o_mar_value    (o_out.mar_value),
        .o_halted       (o_out.halted),
        .o_opcode_done  (o_out.opcode_done),
        .o_illegal_op   (o_out.illegal_op),
        .o_read_data    (o_out.read_data)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for accumulator_cpu_step: directed and random memory writes, reads and
// instruction steps, checked against an in-bench model of the machine.
// Depends on acs_pkg, acs_in_if, acs_out_if and the RTL of the block.
`default_nettype none

module tb;
    import acs_pkg::*;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [15:0] mar;
        logic        halted;
        logic [7:0]  opcode;
        logic        illegal;
        logic [7:0]  rdata;
    } t_status;

    logic i_clk;
    logic i_rst_n;
    acs_in_if  in_ch();
    acs_out_if out_ch();

    accumulator_cpu_step dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Shadow machine state.
    logic [7:0]  cpu_mem [0:MEM_DEPTH-1];
    logic [15:0] cpu_pc;
    logic [7:0]  cpu_acc;
    logic [15:0] cpu_mar;

    t_status expected_status[$];
    int mismatches;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [15:0] alu_result(input logic [2:0] fn, input logic [15:0] d,
                                               input logic [15:0] s);
        case (fn)
            ALU_AND: return d & s;
            ALU_OR:  return d | s;
            ALU_XOR: return d ^ s;
            ALU_ADD: return d + s;
            ALU_SUB: return d - s;
            ALU_INC: return d + 16'd1;
            ALU_DEC: return d - 16'd1;
            default: return ~s;
        endcase
    endfunction

    // Executes the instruction at PC; returns 1 for an unknown opcode.
    function automatic logic run_instruction(input logic [7:0] ir);
        logic [15:0] pc_now, abs_a, nxt, ea, len, s, d, r;
        logic [7:0]  b1, b2;
        logic [1:0]  dst, src, mtd;
        logic        ld, use_mar, take, illegal;
        logic signed [7:0] sacc;
        pc_now = cpu_pc;
        b1 = cpu_mem[pc_now + 16'd1];
        b2 = cpu_mem[pc_now + 16'd2];
        abs_a = {b1, b2};
        len = 16'd1;
        illegal = 1'b0;
        if (ir == OP_NOP) begin
            len = 16'd1;
        end else if (ir[7]) begin
            dst = ir[3:2];
            src = ir[1:0];
            case (src)
                OPD_MAR_MEM: s = {8'h00, cpu_mem[cpu_mar]};
                OPD_ACC:     s = {8'h00, cpu_acc};
                OPD_IMM:     s = (dst == OPD_IMM) ? abs_a : {8'h00, b1};
                default:     s = {8'h00, cpu_mem[abs_a]};
            endcase
            if (src == OPD_ABS) len = len + 16'd2;
            else if (src == OPD_IMM) len = len + ((dst == OPD_IMM) ? 16'd2 : 16'd1);
            if (dst == OPD_ABS) len = len + 16'd2;
            if (dst == OPD_IMM) begin
                cpu_mar = alu_result(ir[6:4], cpu_mar, s);
            end else if (dst == OPD_ACC) begin
                r = alu_result(ir[6:4], {8'h00, cpu_acc}, s);
                cpu_acc = r[7:0];
            end else begin
                ea = (dst == OPD_MAR_MEM) ? cpu_mar : abs_a;
                d = {8'h00, cpu_mem[ea]};
                r = alu_result(ir[6:4], d, s);
                cpu_mem[ea] = r[7:0];
            end
        end else if (ir[7:4] == 4'h0) begin
            ld = ir[3];
            use_mar = ir[2];
            mtd = ir[1:0];
            ea = (mtd == MTD_ABS) ? abs_a : cpu_mar;
            if (mtd == MTD_ABS) len = 16'd3;
            else if (mtd == MTD_IMM) len = use_mar ? 16'd3 : 16'd2;
            if (mtd != MTD_NONE) begin
                if (!use_mar) begin
                    if (ld) cpu_acc = (mtd == MTD_IMM) ? b1 : cpu_mem[ea];
                    else if (mtd != MTD_IMM) cpu_mem[ea] = cpu_acc;
                end else begin
                    if (ld) begin
                        cpu_mar = (mtd == MTD_IMM) ? abs_a
                                                   : {cpu_mem[ea], cpu_mem[ea + 16'd1]};
                    end else if (mtd != MTD_IMM) begin
                        cpu_mem[ea] = cpu_mar[15:8];
                        cpu_mem[ea + 16'd1] = cpu_mar[7:0];
                    end
                end
            end
        end else if ((ir & BR_MASK) == BR_CODE) begin
            len = 16'd3;
        end else begin
            illegal = 1'b1;
        end
        nxt = pc_now + len;
        if ((ir & BR_MASK) == BR_CODE) begin
            sacc = cpu_acc;
            case (ir[2:0])
                BR_ALWAYS: take = 1'b1;
                BR_EQ:     take = (sacc == 0);
                BR_NE:     take = (sacc != 0);
                BR_LT:     take = (sacc < 0);
                BR_LE:     take = (sacc <= 0);
                BR_GT:     take = (sacc > 0);
                BR_GE:     take = (sacc >= 0);
                default:   take = 1'b0;
            endcase
            if (take) nxt = abs_a;
        end
        cpu_pc = nxt;
        return illegal;
    endfunction

    function automatic t_status predict_status(input logic [1:0] fn, input logic [15:0] addr,
                                               input logic [7:0] data);
        t_status st;
        logic [7:0] ir;
        st = '0;
        if (fn == FN_WRITE) begin
            cpu_mem[addr] = data;
        end else if (fn == FN_READ) begin
            st.rdata = cpu_mem[addr];
        end else if (fn == FN_EXEC) begin
            ir = cpu_mem[cpu_pc];
            if (ir != OP_HALT) begin
                st.opcode = ir;
                st.illegal = run_instruction(ir);
            end
        end
        st.pc = cpu_pc;
        st.acc = cpu_acc;
        st.mar = cpu_mar;
        st.halted = (cpu_mem[cpu_pc] == OP_HALT);
        return st;
    endfunction

    // Valid stays high after acceptance until the next call either idles or
    // presents the next transaction at the same falling edge.
    task automatic send_item(input logic [1:0] fn, input logic [15:0] addr,
                             input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= fn;
        in_ch.load_address <= addr;
        in_ch.load_data <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_status.push_back(predict_status(fn, addr, data));
        @(negedge i_clk);
    endtask

    // Writes three consecutive bytes starting at addr.
    task automatic put_bytes(input logic [15:0] addr, input logic [7:0] b0,
                             input logic [7:0] b1, input logic [7:0] b2);
        send_item(FN_WRITE, addr, b0);
        send_item(FN_WRITE, addr + 16'd1, b1);
        send_item(FN_WRITE, addr + 16'd2, b2);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_status.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        // Field extremes, func 3, the halt flag, illegal opcode, store to constant.
        send_item(FN_WRITE, 16'hffff, 8'hff);
        send_item(FN_READ, 16'hffff, 8'h00);
        send_item(FN_READ, 16'h0000, 8'hff);
        send_item(2'd3, 16'haaaa, 8'h55);
        put_bytes(16'h0000, 8'h09, 8'h80, 8'h00);      // load ACC constant 0x80
        send_item(FN_EXEC, 16'h0, 8'h0);
        send_item(FN_WRITE, 16'h0002, 8'h13);          // branch if negative
        send_item(FN_WRITE, 16'h0003, 8'hff);
        send_item(FN_WRITE, 16'h0004, 8'hfe);
        send_item(FN_EXEC, 16'h0, 8'h0);
        put_bytes(16'hfffe, 8'h0d, 8'h12, 8'h34);      // MAR load wraps PC
        send_item(FN_EXEC, 16'h0, 8'h0);
        send_item(FN_WRITE, 16'hfffe, 8'h05);          // store to constant
        send_item(FN_EXEC, 16'h0, 8'h0);
        send_item(FN_WRITE, 16'h0001, 8'h20);          // illegal opcode
        send_item(FN_EXEC, 16'h0, 8'h0);
        send_item(FN_WRITE, 16'h0002, OP_HALT);
        send_item(FN_EXEC, 16'h0, 8'h0);
        send_item(FN_EXEC, 16'h0, 8'h0);
        send_item(FN_WRITE, 16'h0002, OP_NOP);
        send_item(FN_EXEC, 16'h0, 8'h0);
    endtask

    // Random requests, reads near MAR, random instructions placed at PC and then executed, and plain steps.
    task automatic test_random(input int count);
        logic [7:0] op;
        int k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0: send_item(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
                1: send_item(FN_READ, cpu_mar + 16'($urandom_range(3)), 8'($urandom));
                2, 3: begin
                    op = 8'($urandom);
                    if ($urandom_range(3) == 0) op = {5'b00010, 3'($urandom)};
                    if ($urandom_range(4) == 0) op = {4'h0, 4'($urandom)};
                    send_item(FN_WRITE, cpu_pc, op);
                    send_item(FN_WRITE, cpu_pc + 16'd1,
                              ($urandom_range(1) ? 8'($urandom) : 8'($urandom_range(1))));
                    send_item(FN_WRITE, cpu_pc + 16'd2, 8'($urandom));
                    send_item(FN_EXEC, 16'($urandom), 8'($urandom));
                end
                default: send_item(FN_EXEC, 16'($urandom), 8'($urandom));
            endcase
        end
    endtask

    task automatic test_backpressure();
        int k;
        recv_hold = 300;
        for (k = 0; k < 30; k++) send_item(FN_EXEC, 16'h0, 8'h0);
        wait_drained();
        for (k = 0; k < 8; k++) send_item(FN_READ, 16'($urandom), 8'h0);
    endtask

    // Receiver: random stalls plus a long hold-off counted in cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_status want, got;
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.pc_value, out_ch.acc_value, out_ch.mar_value, out_ch.halted,
                    out_ch.opcode_done, out_ch.illegal_op, out_ch.read_data};
            results_seen++;
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %p", got);
            end else begin
                want = expected_status.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            if (cycles > 64'd3000000) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int k;
        for (k = 0; k < MEM_DEPTH; k++) cpu_mem[k] = 8'h00;
        cpu_pc = '0;
        cpu_acc = '0;
        cpu_mar = '0;
        mismatches = 0;
        results_seen = 0;
        recv_hold = 0;
        send_idle_pct = 22;
        recv_idle_pct = 54;
        in_ch.valid = 1'b0;
        in_ch.func = FN_WRITE;
        in_ch.load_address = '0;
        in_ch.load_data = '0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(185);
        send_idle_pct = 54;
        recv_idle_pct = 22;
        test_backpressure();
        test_random(185);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(185);
        wait_drained();
        repeat (40) @(negedge i_clk);
        $display("covered memory writes and reads, all opcode classes, halt, illegal ops");
        $display("and %0d results under three stall patterns", results_seen);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
